FILE: hw/rtl/fwdc_pkg.sv
// ----------------------------------------------------------------------------
// fwdc_pkg
// Shared types, constants and helper functions of the write-drain scheduler.
// ----------------------------------------------------------------------------
package fwdc_pkg;

  localparam int CHAN_SLOTS   = 4;
  localparam int CHAN_W       = 2;
  localparam int IDS_PER_CHAN = 16;
  localparam int BANK_W       = 4;
  localparam int MASK_W       = 64;
  localparam int SLOT_FW      = 6;
  localparam int LEN_W        = 7;
  localparam int CNT_W        = 16;
  localparam int CFG_IDX_W    = 1;

  localparam int NUM_CHAN_DEF       = 4;
  localparam int RANKS_PER_CHAN_DEF = 2;
  localparam int BANKS_PER_RANK_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 64;

  localparam logic [LEN_W-1:0] HIGH_MARK_RESET = 7'd40;
  localparam logic [LEN_W-1:0] LOW_MARK_RESET  = 7'd20;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 1'b1;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_SCHED  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               is_write;
    logic [SLOT_FW-1:0] slot;
  } pick_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } pre_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [SLOT_FW-1:0] lowest_bit(input logic [MASK_W-1:0] v);
    logic [SLOT_FW-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_FW'(i);
    end
    return idx;
  endfunction

  function automatic logic [BANK_W-1:0] lowest_bank(input logic [IDS_PER_CHAN-1:0] v);
    logic [BANK_W-1:0] idx;
    idx = '0;
    for (int i = IDS_PER_CHAN - 1; i >= 0; i--) begin
      if (v[i]) idx = BANK_W'(i);
    end
    return idx;
  endfunction

  // Slot bits that exist in a queue of the given depth.
  function automatic logic [MASK_W-1:0] depth_mask(input int depth);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (i < depth);
    end
    return m;
  endfunction

  // Rank-bank ids that exist in the configured geometry.
  function automatic logic [IDS_PER_CHAN-1:0] bank_cfg_mask(input int ranks, input int banks);
    logic [IDS_PER_CHAN-1:0] m;
    m = '0;
    for (int i = 0; i < IDS_PER_CHAN; i++) begin
      m[i] = ((i >> 3) < ranks) && ((i & 7) < banks);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/fwdc_ram.sv
// ----------------------------------------------------------------------------
// fwdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fwdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fwdc_pick.sv
// ----------------------------------------------------------------------------
// fwdc_pick
// Drain decision, oldest-ready request pick and idle-cycle precharge choice.
// ----------------------------------------------------------------------------
module fwdc_pick import fwdc_pkg::*; #(
  parameter int RANKS_PER_CHAN = RANKS_PER_CHAN_DEF,
  parameter int BANKS_PER_RANK = BANKS_PER_RANK_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                    drain_cur,
  input  logic [LEN_W-1:0]        high_mark,
  input  logic [LEN_W-1:0]        low_mark,
  input  logic [LEN_W-1:0]        read_len,
  input  logic [LEN_W-1:0]        write_len,
  input  logic [MASK_W-1:0]       read_issuable,
  input  logic [MASK_W-1:0]       read_hit,
  input  logic [MASK_W-1:0]       write_issuable,
  input  logic [MASK_W-1:0]       write_hit,
  input  logic [IDS_PER_CHAN-1:0] precharge_ok,
  input  logic [IDS_PER_CHAN-1:0] bank_has_hits,
  output logic                    drain,
  output pick_t                   pick,
  output pre_t                    pre
);

  localparam logic [MASK_W-1:0]       DMASK = depth_mask(QUEUE_DEPTH);
  localparam logic [IDS_PER_CHAN-1:0] BMASK = bank_cfg_mask(RANKS_PER_CHAN, BANKS_PER_RANK);

  logic [MASK_W-1:0]       iss;
  logic [MASK_W-1:0]       cand;
  logic [IDS_PER_CHAN-1:0] pre_cand;

  always_comb begin
    drain = (drain_cur && (write_len > low_mark)) || (write_len > high_mark) ||
            (read_len == '0);
    iss  = (drain ? write_issuable : read_issuable) & DMASK;
    cand = iss & (drain ? write_hit : read_hit);

    pick.valid    = (iss != '0);
    pick.hit      = (cand != '0);
    pick.is_write = pick.valid && drain;
    pick.slot     = '0;
    if (pick.hit) begin
      pick.slot = lowest_bit(cand);
    end else if (pick.valid) begin
      pick.slot = lowest_bit(iss);
    end

    // A precharge only goes out on a cycle that issues no request.
    pre_cand  = bank_has_hits & precharge_ok & BMASK;
    pre.valid = !pick.valid && (pre_cand != '0);
    pre.bank  = pre.valid ? lowest_bank(pre_cand) : '0;
  end

endmodule

FILE: hw/rtl/frfcfs_write_drain_close_page_core.sv
// ----------------------------------------------------------------------------
// frfcfs_write_drain_close_page_core
// Per-channel FR-FCFS command picker with write-drain hysteresis and
// idle-cycle close-page precharge.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; its result appears
// on the out_ ports for exactly one cycle, marked by out_valid, in the cycle
// after acceptance, and the receiver cannot hold it off. A record word and a
// scheduling word that issues no request leave busy low. One that issues a
// row miss keeps busy high through S_LOOK, and one that issues a row hit
// through S_LOOK and S_UPD: the slot-bank memory is read to find the
// bank, then the hit counter memory is read, incremented and written back.
// Per-bank "has hits" flags in flip-flops shadow the counters, so the counter
// memory needs no clearing pass after reset and the precharge search never
// reads it.
module frfcfs_write_drain_close_page_core import fwdc_pkg::*; #(
  parameter int NUM_CHAN       = NUM_CHAN_DEF,
  parameter int RANKS_PER_CHAN = RANKS_PER_CHAN_DEF,
  parameter int BANKS_PER_RANK = BANKS_PER_RANK_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [LEN_W-1:0]        cfg_wdata,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [CHAN_W-1:0]       in_channel,
  input  logic                    in_queue_sel,
  input  logic [SLOT_FW-1:0]      in_slot,
  input  logic [BANK_W-1:0]       in_entry_bank_id,
  input  logic [LEN_W-1:0]        in_read_len,
  input  logic [LEN_W-1:0]        in_write_len,
  input  logic [MASK_W-1:0]       in_read_issuable,
  input  logic [MASK_W-1:0]       in_read_hit,
  input  logic [MASK_W-1:0]       in_write_issuable,
  input  logic [MASK_W-1:0]       in_write_hit,
  input  logic [IDS_PER_CHAN-1:0] in_precharge_ok,
  output logic                    out_valid,
  output logic                    out_issue_valid,
  output logic                    out_issue_is_write,
  output logic [SLOT_FW-1:0]      out_issue_slot,
  output logic                    out_issue_row_hit,
  output logic                    out_precharge_valid,
  output logic [BANK_W-1:0]       out_precharge_bank,
  output logic                    out_draining
);

  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int SADDR_W  = CHAN_W + 1 + SLOT_W;
  localparam int SDEPTH   = 1 << SADDR_W;
  localparam int CADDR_W  = CHAN_W + BANK_W;
  localparam int CDEPTH   = 1 << CADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t                                    state_r;
  logic [LEN_W-1:0]                          high_mark_r;
  logic [LEN_W-1:0]                          low_mark_r;
  logic [CHAN_SLOTS-1:0]                     drain_flag_r;
  logic [CHAN_SLOTS-1:0][IDS_PER_CHAN-1:0]   nz_r;
  logic [CHAN_W-1:0]                         chan_r;
  logic                                      hit_r;
  logic                                      old_nz_r;
  logic [CADDR_W-1:0]                        cnt_waddr_r;

  logic                    out_valid_r;
  logic                    out_issue_valid_r;
  logic                    out_issue_is_write_r;
  logic [SLOT_FW-1:0]      out_issue_slot_r;
  logic                    out_issue_row_hit_r;
  logic                    out_precharge_valid_r;
  logic [BANK_W-1:0]       out_precharge_bank_r;
  logic                    out_draining_r;

  logic                    accept;
  logic                    chan_ok;
  logic                    drain;
  pick_t                   pick;
  pre_t                    pre;

  logic                    slot_we;
  logic [SADDR_W-1:0]      slot_waddr;
  logic [SADDR_W-1:0]      slot_raddr;
  logic [BANK_W-1:0]       slot_rdata;

  logic                    cnt_we;
  logic [CADDR_W-1:0]      cnt_raddr;
  logic [CNT_W-1:0]        cnt_rdata;
  logic [CNT_W-1:0]        cnt_wdata;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign chan_ok = (int'(in_channel) < NUM_CHAN);

  fwdc_pick #(
    .RANKS_PER_CHAN(RANKS_PER_CHAN),
    .BANKS_PER_RANK(BANKS_PER_RANK),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_pick (
    .drain_cur     (drain_flag_r[in_channel]),
    .high_mark     (high_mark_r),
    .low_mark      (low_mark_r),
    .read_len      (in_read_len),
    .write_len     (in_write_len),
    .read_issuable (in_read_issuable),
    .read_hit      (in_read_hit),
    .write_issuable(in_write_issuable),
    .write_hit     (in_write_hit),
    .precharge_ok  (in_precharge_ok),
    .bank_has_hits (nz_r[in_channel]),
    .drain         (drain),
    .pick          (pick),
    .pre           (pre)
  );

  assign slot_we    = accept && chan_ok && (in_func == FUNC_RECORD) &&
                      ({1'b0, in_slot} < (SLOT_FW + 1)'(QUEUE_DEPTH));
  assign slot_waddr = {in_channel, in_queue_sel, in_slot[SLOT_W-1:0]};
  assign slot_raddr = {in_channel, drain, pick.slot[SLOT_W-1:0]};

  fwdc_ram #(
    .WIDTH(BANK_W),
    .DEPTH(SDEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(in_entry_bank_id),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  // A counter whose has-hits flag is clear reads as zero, whatever the memory holds.
  assign cnt_raddr = {chan_r, slot_rdata};
  assign cnt_we    = (state_r == S_UPD);
  assign cnt_wdata = !old_nz_r ? CNT_W'(1) :
                     (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + CNT_W'(1);

  fwdc_ram #(
    .WIDTH(CNT_W),
    .DEPTH(CDEPTH)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr_r),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r               <= S_IDLE;
      high_mark_r           <= HIGH_MARK_RESET;
      low_mark_r            <= LOW_MARK_RESET;
      drain_flag_r          <= '0;
      nz_r                  <= '0;
      chan_r                <= '0;
      hit_r                 <= 1'b0;
      old_nz_r              <= 1'b0;
      cnt_waddr_r           <= '0;
      out_valid_r           <= 1'b0;
      out_issue_valid_r     <= 1'b0;
      out_issue_is_write_r  <= 1'b0;
      out_issue_slot_r      <= '0;
      out_issue_row_hit_r   <= 1'b0;
      out_precharge_valid_r <= 1'b0;
      out_precharge_bank_r  <= '0;
      out_draining_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HIGH_MARK: high_mark_r <= cfg_wdata;
          REG_LOW_MARK:  low_mark_r  <= cfg_wdata;
          default: ;
        endcase
      end

      out_valid_r <= accept;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (chan_ok && (in_func == FUNC_SCHED)) begin
              drain_flag_r[in_channel] <= drain;
              out_draining_r           <= drain;
              out_issue_valid_r        <= pick.valid;
              out_issue_is_write_r     <= pick.is_write;
              out_issue_slot_r         <= pick.slot;
              out_issue_row_hit_r      <= pick.hit;
              out_precharge_valid_r    <= pre.valid;
              out_precharge_bank_r     <= pre.bank;
              if (pick.valid) begin
                chan_r  <= in_channel;
                hit_r   <= pick.hit;
                state_r <= S_LOOK;
              end else if (pre.valid) begin
                nz_r[in_channel][pre.bank] <= 1'b0;
              end
            end else begin
              // A record word, or one for a missing channel, reports only the flag.
              out_issue_valid_r     <= 1'b0;
              out_issue_is_write_r  <= 1'b0;
              out_issue_slot_r      <= '0;
              out_issue_row_hit_r   <= 1'b0;
              out_precharge_valid_r <= 1'b0;
              out_precharge_bank_r  <= '0;
              out_draining_r        <= chan_ok && drain_flag_r[in_channel];
            end
          end
        end
        S_LOOK: begin
          // The bank of the picked slot is known now; a miss just clears its flag.
          nz_r[chan_r][slot_rdata] <= hit_r;
          old_nz_r                 <= nz_r[chan_r][slot_rdata];
          cnt_waddr_r              <= {chan_r, slot_rdata};
          state_r                  <= hit_r ? S_UPD : S_IDLE;
        end
        S_UPD: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_issue_valid     = out_issue_valid_r;
  assign out_issue_is_write  = out_issue_is_write_r;
  assign out_issue_slot      = out_issue_slot_r;
  assign out_issue_row_hit   = out_issue_row_hit_r;
  assign out_precharge_valid = out_precharge_valid_r;
  assign out_precharge_bank  = out_precharge_bank_r;
  assign out_draining        = out_draining_r;

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an accepted word");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_issue_valid && out_precharge_valid))
    else $error("request and precharge issued together");

  a_write_needs_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issue_is_write) |-> out_draining)
    else $error("write issued outside drain mode");

  a_flag_tracks_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=>
      (nz_r[cnt_waddr_r[CADDR_W-1:BANK_W]][cnt_waddr_r[BANK_W-1:0]] == $past(hit_r)))
    else $error("has-hits flag not updated by issued request");

endmodule
